[src/circle_map_orbit_support_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the circle map orbit support core
// ---------------------------------------------------------------------------
`ifndef CIRCLE_MAP_ORBIT_SUPPORT_CORE_DEFINES_SVH
`define CIRCLE_MAP_ORBIT_SUPPORT_CORE_DEFINES_SVH
`ifndef SYNTH
`define CMOS_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define CMOS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define CMOS_ASSERT_IMP(label, clk, rst, a, b)
`define CMOS_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[src/cmos_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle map orbit support package
// Constants, register indexes and the sine table builder.
// ---------------------------------------------------------------------------
package cmos_pkg;
   localparam int BIN_COUNT_DEF  = 1024;
   localparam int SINE_SIZE_DEF  = 4096;
   localparam int COUNT_BITS_DEF = 20;

   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [10:0] SUPPORT_MAX = 11'd2047;

   localparam logic [15:0] SETTLE_RESET  = 16'd190;
   localparam logic [19:0] MEASURE_RESET = 20'd8111;

   typedef enum logic [2:0] {
      REG_PHASE_STEP    = 3'd0,
      REG_COUPLING      = 3'd1,
      REG_SETTLE_STEPS  = 3'd2,
      REG_MEASURE_STEPS = 3'd3,
      REG_MIN_COUNT     = 3'd4
   } reg_index_type;

   function automatic logic [63:0] taylor_mul(logic [63:0] t, logic [63:0] x2);
      taylor_mul = (t * x2 + (ONE_Q30 >> 1)) >> 30;
   endfunction

   // theta in Q30, angle in [0, 2*pi)
   function automatic logic signed [31:0] sine_fold(logic [63:0] theta_in);
      logic        neg;
      logic [63:0] th;
      logic [63:0] x2;
      logic [63:0] t;
      logic signed [63:0] sum;
      neg = 1'b0;
      th  = theta_in;
      if (th >= PI_Q30) begin
         neg = 1'b1;
         th  = th - PI_Q30;
      end
      if (th > HALF_PI_Q30) th = PI_Q30 - th;
      x2  = (th * th + (ONE_Q30 >> 1)) >> 30;
      sum = $signed(th);
      t = (taylor_mul(th, x2) + 64'd3) / 64'd6;    sum = sum - $signed(t);
      t = (taylor_mul(t, x2) + 64'd10) / 64'd20;   sum = sum + $signed(t);
      t = (taylor_mul(t, x2) + 64'd21) / 64'd42;   sum = sum - $signed(t);
      t = (taylor_mul(t, x2) + 64'd36) / 64'd72;   sum = sum + $signed(t);
      t = (taylor_mul(t, x2) + 64'd55) / 64'd110;  sum = sum - $signed(t);
      t = (taylor_mul(t, x2) + 64'd78) / 64'd156;  sum = sum + $signed(t);
      t = (taylor_mul(t, x2) + 64'd105) / 64'd210; sum = sum - $signed(t);
      if (sum < 0) sum = 0;
      if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
      sine_fold = neg ? 32'(-sum) : 32'(sum);
   endfunction
endpackage

[src/circle_map_orbit_support_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle map orbit support core
// Runs one circle map orbit per request and counts the bins whose visit count exceeds min_count.
// ---------------------------------------------------------------------------
// channel  | direction | payload
// req      | in        | tdata[31:0] start_phase
// rsp      | out       | tdata[10:0] support_bins
// csr      | in        | write index / data, no read-back
//
// One run: a pass clearing the bin memory, then for settle_steps+measure_steps
// orbit steps a sine ROM read, a multiply and a phase add each, a tail state,
// then a scan of the bin memory through its single read port, and a final
// state presenting the result. Bin updates ride the read port during the
// step and write back in the next cycle. Reset is synchronous; a request is
// taken only while idle and the result is held until the rsp transfer.
// ---------------------------------------------------------------------------
`include "circle_map_orbit_support_core_defines.svh"

module circle_map_orbit_support_core #(
   parameter int BIN_COUNT       = cmos_pkg::BIN_COUNT_DEF,
   parameter int SINE_TABLE_SIZE = cmos_pkg::SINE_SIZE_DEF,
   parameter int COUNT_BITS      = cmos_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] start_phase
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [10:0] support_bins, rest zero
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import cmos_pkg::*;

   localparam int BIN_BITS  = $clog2(BIN_COUNT);
   localparam int SINE_BITS = $clog2(SINE_TABLE_SIZE);
   localparam logic [COUNT_BITS-1:0] CAP = {COUNT_BITS{1'b1}};
   localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(BIN_COUNT - 1);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_CLEAR    = 8'b0000_0010,
      ST_A        = 8'b0000_0100,
      ST_B        = 8'b0000_1000,
      ST_C        = 8'b0001_0000,
      ST_TAIL     = 8'b0010_0000,
      ST_SCAN     = 8'b0100_0000,
      ST_SCAN_END = 8'b1000_0000
   } state_type;

   // sine ROM from elaboration-time constants
   logic signed [31:0] sine_rom [SINE_TABLE_SIZE];
   for (genvar g = 0; g < SINE_TABLE_SIZE; g++) begin : g_rom
      localparam logic [63:0] THETA =
         (64'(g) * (64'd2 * PI_Q30) + 64'(SINE_TABLE_SIZE / 2)) / 64'(SINE_TABLE_SIZE);
      assign sine_rom[g] = sine_fold(THETA);
   end

   logic [COUNT_BITS-1:0] bin_mem [BIN_COUNT];

   state_type state_ff, state_in;
   logic [31:0] phase_step_ff;
   logic signed [31:0] coupling_ff;
   logic [15:0] settle_ff;
   logic [19:0] measure_ff;
   logic [19:0] min_count_ff;
   logic [31:0] phase_ff;
   logic [15:0] settle_left_ff;
   logic [19:0] meas_left_ff;
   logic        bin_pend_ff;
   logic [BIN_BITS-1:0] bin_addr_ff;
   logic [BIN_BITS-1:0] sweep_ff;
   logic        scan_vld_ff;
   logic [10:0] support_ff;
   logic        done_ff;
   logic signed [31:0] sine_ff;
   logic signed [63:0] prod_ff;
   logic [COUNT_BITS-1:0] bin_q;

   logic [SINE_BITS-1:0] sine_idx;
   logic [BIN_BITS-1:0]  cur_bin;
   logic [BIN_BITS-1:0]  rd_addr;
   logic                 wr_en;
   logic [BIN_BITS-1:0]  wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [63:0] rounded;
   logic [31:0] kick;

   assign sine_idx = SINE_BITS'((64'(phase_ff) * 64'(SINE_TABLE_SIZE)) >> 32);
   assign cur_bin  = BIN_BITS'((64'(phase_ff) * 64'(BIN_COUNT)) >> 32);
   assign rounded  = 64'(prod_ff) + 64'd33554432;
   assign kick     = rounded[57:26];

   assign req_tready = (state_ff == ST_IDLE) && !done_ff;
   assign rsp_tvalid = done_ff;
   assign rsp_tdata  = {5'd0, support_ff};

   always_comb begin
      rd_addr = (state_ff == ST_SCAN) ? sweep_ff : cur_bin;
      wr_en   = 1'b0;
      wr_addr = bin_addr_ff;
      wr_data = (bin_q == CAP) ? CAP : bin_q + 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = '0;
         end
         ST_B, ST_TAIL: wr_en = bin_pend_ff;
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) bin_mem[wr_addr] <= wr_data;
      bin_q   <= bin_mem[rd_addr];
      sine_ff <= sine_rom[sine_idx];
      prod_ff <= 64'(coupling_ff) * 64'(sine_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid && req_tready) state_in = ST_CLEAR;
         ST_CLEAR: if (sweep_ff == LAST_BIN) state_in = ST_A;
         ST_A: begin
            if (settle_left_ff == '0 && meas_left_ff == '0) state_in = ST_TAIL;
            else state_in = ST_B;
         end
         ST_B:        state_in = ST_C;
         ST_C:        state_in = ST_A;
         ST_TAIL:     state_in = ST_SCAN;
         ST_SCAN:     if (sweep_ff == LAST_BIN) state_in = ST_SCAN_END;
         ST_SCAN_END: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_step_ff <= '0;
         coupling_ff   <= '0;
         settle_ff     <= SETTLE_RESET;
         measure_ff    <= MEASURE_RESET;
         min_count_ff  <= '0;
         done_ff       <= 1'b0;
         scan_vld_ff   <= 1'b0;
         bin_pend_ff   <= 1'b0;
         sweep_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         scan_vld_ff <= (state_ff == ST_SCAN);
         if (csr_we) begin
            case (csr_index)
               REG_PHASE_STEP:    phase_step_ff <= csr_wdata;
               REG_COUPLING:      coupling_ff   <= csr_wdata;
               REG_SETTLE_STEPS:  settle_ff     <= csr_wdata[15:0];
               REG_MEASURE_STEPS: measure_ff    <= csr_wdata[19:0];
               REG_MIN_COUNT:     min_count_ff  <= csr_wdata[19:0];
               default: ;
            endcase
         end
         if (done_ff && rsp_tready) done_ff <= 1'b0;
         // count a bin in the cycle after its scan read
         if (scan_vld_ff && 32'(bin_q) > 32'(min_count_ff) && support_ff != SUPPORT_MAX)
            support_ff <= support_ff + 11'd1;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  phase_ff       <= req_tdata;
                  settle_left_ff <= settle_ff;
                  meas_left_ff   <= measure_ff;
                  bin_pend_ff    <= 1'b0;
                  support_ff     <= '0;
                  sweep_ff       <= '0;
               end
            end
            ST_CLEAR, ST_SCAN: sweep_ff <= sweep_ff + 1'b1;
            ST_A: bin_addr_ff <= cur_bin;
            ST_B: bin_pend_ff <= 1'b0;
            ST_C: begin
               phase_ff <= phase_ff + phase_step_ff - kick;
               if (settle_left_ff != '0) begin
                  settle_left_ff <= settle_left_ff - 1'b1;
               end else begin
                  meas_left_ff <= meas_left_ff - 1'b1;
                  bin_pend_ff  <= 1'b1;
               end
            end
            ST_TAIL: begin
               bin_pend_ff <= 1'b0;
               sweep_ff    <= '0;
            end
            ST_SCAN_END: done_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   `CMOS_ASSERT_IMP(a_rsp_blocks_req, clock, reset, done_ff, !req_tready)
   `CMOS_ASSERT_NEXT(a_step_loops, clock, reset, state_ff == ST_C, state_ff == ST_A)
   `CMOS_ASSERT_IMP(a_wr_states, clock, reset, wr_en, state_ff == ST_CLEAR || state_ff == ST_B || state_ff == ST_TAIL)
endmodule
